// File: sv/pcbd_pkg.sv
// types, constants and helpers shared by the prefix code bit decoder
package pcbd_pkg;

    localparam int unsigned IDX_W  = 8;
    localparam int unsigned CODE_W = 32;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned CNT_W  = 9;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [SYM_W-1:0] BAR_SYMBOL     = 8'd124;
    localparam logic [SYM_W-1:0] NEWLINE_SYMBOL = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  index;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
    } load_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [SYM_W-1:0] sym;
    } link_t;

    function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] mask;
        if (len >= LEN_W'(CODE_W))
            mask = '1;
        else
            mask = (CODE_W'(1) << len) - CODE_W'(1);
        return mask;
    endfunction

    function automatic logic [SYM_W-1:0] map_symbol(input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] res;
        if (sym == BAR_SYMBOL)
            res = NEWLINE_SYMBOL;
        else
            res = sym;
        return res;
    endfunction

endpackage

// File: sv/pcbd_cell.sv
// one code table entry with its comparator and a stage of the priority token chain
module pcbd_cell
    import pcbd_pkg::*;
#(
    parameter int unsigned INDEX  = 0,
    parameter int unsigned PEND_W = 32,
    parameter int unsigned PLEN_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  load_t             load,
    input  logic [PEND_W-1:0] pend_bits,
    input  logic [PLEN_W-1:0] pend_len,
    input  logic [CNT_W-1:0]  entry_count,
    input  link_t             link_in,
    output link_t             link_out
);

    localparam int unsigned CMP_W  = (PEND_W > CODE_W) ? PEND_W : CODE_W;
    localparam int unsigned LCMP_W = (PLEN_W > LEN_W) ? PLEN_W : LEN_W;

    logic [CODE_W-1:0] code_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SYM_W-1:0]  sym_reg;
    link_t             link_reg;
    link_t             link_next;
    logic              wr_en;
    logic              active;
    logic              match;

    assign wr_en  = load.en && (32'(load.index) == INDEX);
    assign active = INDEX < 32'(entry_count);
    assign match  = active
                 && (LCMP_W'(len_reg) == LCMP_W'(pend_len))
                 && (CMP_W'(code_reg) == CMP_W'(pend_bits));

    always_comb
    begin
        link_next.valid = link_in.valid;
        link_next.hit   = link_in.hit || (link_in.valid && match);
        link_next.sym   = link_in.hit ? link_in.sym : sym_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_reg <= load.code;
            len_reg  <= load.len;
            sym_reg  <= load.sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            link_reg <= '0;
        else
            link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule

// File: sv/pcbd_chain.sv
// row of table cells that a search token walks from entry 0 upward
module pcbd_chain
    import pcbd_pkg::*;
#(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned PEND_W = 32,
    parameter int unsigned PLEN_W = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  load_t             load,
    input  logic [PEND_W-1:0] pend_bits,
    input  logic [PLEN_W-1:0] pend_len,
    input  logic [CNT_W-1:0]  entry_count,
    input  link_t             head,
    output link_t             tail
);

    link_t links [DEPTH+1];

    assign links[0] = head;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        pcbd_cell #(
            .INDEX  (i),
            .PEND_W (PEND_W),
            .PLEN_W (PLEN_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (load),
            .pend_bits   (pend_bits),
            .pend_len    (pend_len),
            .entry_count (entry_count),
            .link_in     (links[i]),
            .link_out    (links[i+1])
        );
    end

    assign tail = links[DEPTH];

endmodule

// File: sv/prefix_code_bit_decoder.sv
// prefix code bit decoder: table load, bit buffer, search control and result register
//
// input beats carry either a table load (operation 0) or one coded bit (operation 1)
// a load beat writes one table cell and is done in the cycle it is accepted
// a decode beat appends its bit to the pending buffer and sends a search token
// through a row of TABLE_DEPTH cells, one cell per cycle, until it leaves the last
// cell; in_ready stays low until the search ends and, after a match, until the
// result has moved into the output register
// a decode beat with a full buffer gives an overflow beat
// a decode beat with no match gives no output beat
// entry_count is written over the config channel, which is always ready; write it
// only while no search runs
// the result sits in an output register; while the receiver stalls, the
// block still accepts the next beat and parks a later result until it drains
// reset clears the buffer, entry_count and all handshake state; table contents
// stay undefined until loaded
module prefix_code_bit_decoder
    import pcbd_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH  = 256,
    parameter int unsigned MAX_CODE_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  entry_count,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    input  logic [SYM_W-1:0]  symbol,
    input  logic              coded_bit,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [SYM_W-1:0]  symbol_out,
    output logic              overflow
);

    localparam int unsigned PEND_W = MAX_CODE_LEN;
    localparam int unsigned PLEN_W = $clog2(MAX_CODE_LEN + 1);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [PEND_W-1:0] pend_bits_reg;
    logic [PEND_W-1:0] pend_bits_next;
    logic [PLEN_W-1:0] pend_len_reg;
    logic [PLEN_W-1:0] pend_len_next;
    logic              launch_reg;
    logic              launch_next;
    logic [SYM_W-1:0]  res_sym_reg;
    logic [SYM_W-1:0]  res_sym_next;
    logic              res_ovf_reg;
    logic              res_ovf_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SYM_W-1:0]  symbol_out_reg;
    logic [SYM_W-1:0]  symbol_out_next;
    logic              overflow_reg;
    logic              overflow_next;
    logic              buf_full;
    load_t             load;
    link_t             head;
    link_t             tail;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign buf_full  = pend_len_reg >= PLEN_W'(MAX_CODE_LEN);

    always_comb
    begin
        load.en    = in_valid && in_ready && (operation == OP_LOAD);
        load.index = entry_index;
        load.code  = code_bits & low_mask(code_length);
        load.len   = code_length;
        load.sym   = symbol;
    end

    assign head = '{valid: launch_reg, hit: 1'b0, sym: '0};

    pcbd_chain #(
        .DEPTH  (TABLE_DEPTH),
        .PEND_W (PEND_W),
        .PLEN_W (PLEN_W)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .pend_bits   (pend_bits_reg),
        .pend_len    (pend_len_reg),
        .entry_count (count_reg),
        .head        (head),
        .tail        (tail)
    );

    always_comb
    begin
        state_next      = state_reg;
        pend_bits_next  = pend_bits_reg;
        pend_len_next   = pend_len_reg;
        launch_next     = 1'b0;
        res_sym_next    = res_sym_reg;
        res_ovf_next    = res_ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        symbol_out_next = symbol_out_reg;
        overflow_next   = overflow_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (operation == OP_DECODE))
                begin
                    if (buf_full)
                    begin
                        pend_bits_next = '0;
                        pend_len_next  = '0;
                        res_sym_next   = '0;
                        res_ovf_next   = 1'b1;
                        state_next     = ST_DELIVER;
                    end
                    else
                    begin
                        pend_bits_next = PEND_W'({pend_bits_reg, coded_bit});
                        pend_len_next  = pend_len_reg + PLEN_W'(1);
                        launch_next    = 1'b1;
                        state_next     = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tail.valid)
                begin
                    if (tail.hit)
                    begin
                        pend_bits_next = '0;
                        pend_len_next  = '0;
                        res_sym_next   = map_symbol(tail.sym);
                        res_ovf_next   = 1'b0;
                        state_next     = ST_DELIVER;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    symbol_out_next = res_sym_reg;
                    overflow_next   = res_ovf_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_bits_reg <= '0;
            pend_len_reg  <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_bits_reg <= pend_bits_next;
            pend_len_reg  <= pend_len_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                count_reg <= entry_count;
        end
    end

    always_ff @(posedge clk)
    begin
        res_sym_reg    <= res_sym_next;
        res_ovf_reg    <= res_ovf_next;
        symbol_out_reg <= symbol_out_next;
        overflow_reg   <= overflow_next;
    end

    assign out_valid  = out_valid_reg;
    assign symbol_out = symbol_out_reg;
    assign overflow   = overflow_reg;

    // search token only comes out of the row during a search
    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == ST_SEARCH))
        else $error("search token left the cell row outside a search");

    // buffer never holds more than the longest code
    a_pend_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_len_reg <= PLEN_W'(MAX_CODE_LEN))
        else $error("pending buffer longer than the longest code");

    // a decode beat on a full buffer drops it
    a_overrun_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == OP_DECODE) && buf_full)
        |=> (pend_len_reg == '0) && (state_reg == ST_DELIVER))
        else $error("overrun did not clear the pending buffer");

    // overflow beats carry symbol zero
    a_overflow_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (symbol_out == '0))
        else $error("overflow beat with a nonzero symbol");

    // the bar symbol never leaves unmapped
    a_no_bar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (symbol_out != BAR_SYMBOL))
        else $error("bar symbol sent without newline mapping");

endmodule

// File: verif/tb_prefix_code_bit_decoder.sv
// self-checking testbench for the prefix code bit decoder: table loads, bit decoding, overflow
`timescale 1ns / 100ps

module tb_prefix_code_bit_decoder;
    import pcbd_pkg::*;

    localparam int unsigned DEPTH         = 256;
    localparam int unsigned MAX_LEN       = 32;
    localparam int unsigned SEARCH_CYCLES = DEPTH + 3;
    localparam int unsigned ITEM_TARGET   = 1850;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned HOLD_START    = 40_000;
    localparam int unsigned HOLD_CYCLES   = 4_000;
    localparam int unsigned SHOWN_ERRORS  = 10;
    localparam int unsigned DIR_ROWS      = 21;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
        logic              bit_val;
    } beat_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             ovf;
    } result_t;

    typedef struct packed {
        beat_t      bt;
        logic [5:0] reps;
        logic       typed;
        result_t    res;
    } row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HALF,
        RX_HEAVY
    } rx_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_count;

    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic [IDX_W-1:0]  entry_index;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  symbol;
    logic              coded_bit;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [SYM_W-1:0]  symbol_out;
    logic              overflow;

    // shadow of the decoder state
    logic [CODE_W-1:0] tbl_code [DEPTH];
    logic [LEN_W-1:0]  tbl_len  [DEPTH];
    logic [SYM_W-1:0]  tbl_sym  [DEPTH];
    logic [CODE_W-1:0] pend_bits;
    int unsigned       pend_len;
    int unsigned       search_count;

    result_t           symbol_q [$];
    result_t           want;
    row_t              dir_rows [DIR_ROWS];
    int unsigned       live_q [$];

    int unsigned       beats_sent;
    int unsigned       loads_sent;
    int unsigned       decodes_sent;
    int unsigned       symbols_seen;
    int unsigned       overflows_seen;
    int unsigned       cfg_writes;
    int unsigned       mismatches;
    int unsigned       burst_left;
    int unsigned       cycle_count;
    int unsigned       rx_left;
    int unsigned       hold_clock;
    rx_mode_t          rx_mode;
    logic              rx_hold = 1'b0;

    prefix_code_bit_decoder #(
        .TABLE_DEPTH  (DEPTH),
        .MAX_CODE_LEN (MAX_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .entry_count  (cfg_count),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .entry_index  (entry_index),
        .code_bits    (code_bits),
        .code_length  (code_length),
        .symbol       (symbol),
        .coded_bit    (coded_bit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol_out   (symbol_out),
        .overflow     (overflow)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic row_t load_row(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code,
                                      input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
        row_t r;
        r         = '0;
        r.bt.op   = OP_LOAD;
        r.bt.idx  = idx;
        r.bt.code = code;
        r.bt.len  = len;
        r.bt.sym  = sym;
        r.reps    = 6'd1;
        return r;
    endfunction

    function automatic row_t bit_row(input logic b, input logic [5:0] reps);
        row_t r;
        r            = '0;
        r.bt.op      = OP_DECODE;
        r.bt.bit_val = b;
        r.reps       = reps;
        return r;
    endfunction

    function automatic row_t sym_row(input logic b, input logic [SYM_W-1:0] sym, input logic ovf);
        row_t r;
        r         = bit_row(b, 6'd1);
        r.typed   = 1'b1;
        r.res.sym = sym;
        r.res.ovf = ovf;
        return r;
    endfunction

    function automatic beat_t rand_beat(input logic op);
        beat_t       b;
        int unsigned pick;
        pick      = $urandom_range(0, 19);
        b.op      = op;
        b.idx     = IDX_W'($urandom);
        b.code    = $urandom;
        b.bit_val = 1'($urandom);
        if (pick < 16)
            b.len = LEN_W'($urandom_range(1, 6));
        else if (pick < 19)
            b.len = LEN_W'($urandom_range(7, 16));
        else
            b.len = LEN_W'($urandom_range(17, MAX_LEN));
        if ($urandom_range(0, 7) == 0)
            b.sym = BAR_SYMBOL;
        else
            b.sym = SYM_W'($urandom);
        return b;
    endfunction

    task automatic store_entry(input beat_t bt);
        logic [CODE_W-1:0] mask;
        if (bt.len >= MAX_LEN)
            mask = '1;
        else
            mask = (CODE_W'(1) << bt.len) - CODE_W'(1);
        tbl_len[bt.idx]  = bt.len;
        tbl_code[bt.idx] = bt.code & mask;
        tbl_sym[bt.idx]  = bt.sym;
    endtask

    task automatic decode_bit(input logic b, output logic hit, output result_t res);
        hit = 1'b0;
        res = '0;
        if (pend_len >= MAX_LEN)
        begin
            pend_bits = '0;
            pend_len  = 0;
            hit       = 1'b1;
            res.ovf   = 1'b1;
        end
        else
        begin
            pend_bits = {pend_bits[CODE_W-2:0], b};
            pend_len++;
            for (int unsigned i = 0; i < search_count; i++)
            begin
                if (!hit && tbl_len[i] != 0 && tbl_len[i] <= MAX_LEN &&
                    tbl_len[i] == pend_len && tbl_code[i] == pend_bits)
                begin
                    hit     = 1'b1;
                    res.sym = (tbl_sym[i] == BAR_SYMBOL) ? NEWLINE_SYMBOL : tbl_sym[i];
                end
            end
            if (hit)
            begin
                pend_bits = '0;
                pend_len  = 0;
            end
        end
    endtask

    task automatic send_beat(input beat_t bt, input logic typed, input result_t typed_res);
        int unsigned gap;
        logic        hit;
        result_t     res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(200, 400);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        operation   <= bt.op;
        entry_index <= bt.idx;
        code_bits   <= bt.code;
        code_length <= bt.len;
        symbol      <= bt.sym;
        coded_bit   <= bt.bit_val;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        beats_sent++;
        hit = 1'b0;
        res = '0;
        if (bt.op == OP_LOAD)
        begin
            store_entry(bt);
            loads_sent++;
        end
        else
        begin
            decode_bit(bt.bit_val, hit, res);
            decodes_sent++;
        end
        if (typed)
            symbol_q.insert(symbol_q.size(), typed_res);
        else if (hit)
            symbol_q.insert(symbol_q.size(), res);
    endtask

    // only while the block is idle
    task automatic write_count(input logic [CNT_W-1:0] val);
        in_valid   <= 1'b0;
        burst_left = 0;
        while (symbol_q.size() != 0)
            @(posedge clk);
        repeat (SEARCH_CYCLES + 8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_count <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        search_count = (val > DEPTH) ? DEPTH : val;
        cfg_writes++;
    endtask

    task automatic place_entry(input int unsigned span, input int unsigned fixed_len);
        beat_t b;
        b     = rand_beat(OP_LOAD);
        b.idx = IDX_W'((span == 0) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, span - 1));
        if (fixed_len != 0)
            b.len = LEN_W'(fixed_len);
        send_beat(b, 1'b0, '0);
        live_q.insert(live_q.size(), b.idx);
    endtask

    task automatic feed_code(input int unsigned j, input logic partial);
        int unsigned       width;
        int unsigned       nbits;
        logic [CODE_W-1:0] word;
        beat_t             b;
        width = tbl_len[j];
        word  = tbl_code[j];
        nbits = (partial && width > 1) ? $urandom_range(1, width - 1) : width;
        for (int unsigned k = 0; k < nbits; k++)
        begin
            b         = rand_beat(OP_DECODE);
            b.bit_val = word[width-1-k];
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (symbol_q.size() == 0)
                report_error($sformatf("unexpected beat: symbol %0d overflow %0b",
                                       symbol_out, overflow));
            else
            begin
                want = symbol_q.pop_front();
                if (symbol_out !== want.sym || overflow !== want.ovf)
                    report_error($sformatf(
                        "mismatch: expected symbol %0d overflow %0b, got symbol %0d overflow %0b",
                        want.sym, want.ovf, symbol_out, overflow));
            end
            if (overflow)
                overflows_seen++;
            else
                symbols_seen++;
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_left   = 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(100, 2000);
            end
            rx_left--;
            if (rx_hold)
                out_ready <= 1'b0;
            else
                case (rx_mode)
                    RX_OPEN:  out_ready <= 1'b1;
                    RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:  out_ready <= 1'($urandom);
                    default:  out_ready <= ($urandom_range(0, 9) < 3);
                endcase
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold    <= 1'b0;
            hold_clock = 0;
        end
        else
        begin
            hold_clock++;
            rx_hold <= (hold_clock >= HOLD_START && hold_clock < HOLD_START + HOLD_CYCLES);
        end
    end

    initial
    begin
        beat_t            b;
        logic [CNT_W-1:0] cnt;
        int unsigned      phase;
        int unsigned      span;
        int unsigned      fixed_len;
        int unsigned      pick;
        int unsigned      nbits;

        cfg_valid   <= 1'b0;
        cfg_count   <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_LOAD;
        entry_index <= '0;
        code_bits   <= '0;
        code_length <= '0;
        symbol      <= '0;
        coded_bit   <= 1'b0;
        pend_bits    = '0;
        pend_len     = 0;
        search_count = 0;
        burst_left   = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry written once, all with zero length
        for (int unsigned i = 0; i < DEPTH; i++)
        begin
            b     = rand_beat(OP_LOAD);
            b.idx = IDX_W'(i);
            b.len = '0;
            send_beat(b, 1'b0, '0);
        end
        write_count(CNT_W'(6));

        dir_rows = '{
            // 32 unmatched bits, then an overrun
            bit_row(1'b1, 6'd1),
            bit_row(1'b0, 6'd30),
            bit_row(1'b1, 6'd1),
            sym_row(1'b0, 8'd0, 1'b1),
            load_row(8'd0,   32'h0000_0002, 6'd2,  8'h41),
            load_row(8'd1,   32'h0000_0006, 6'd3,  BAR_SYMBOL),
            // high bits masked off, duplicate of entry 0
            load_row(8'd2,   32'hFFFF_FFFE, 6'd2,  8'hFF),
            load_row(8'd3,   32'hFFFF_FFFF, 6'd32, 8'h00),
            load_row(8'd4,   32'hFFFF_FFF0, 6'd3,  8'h80),
            // lengths that never match
            load_row(8'd5,   32'h0000_0000, 6'd63, 8'h01),
            load_row(8'd255, 32'hFFFF_FFFF, 6'd0,  8'hFF),
            bit_row(1'b1, 6'd1),
            sym_row(1'b0, 8'h41, 1'b0),
            bit_row(1'b1, 6'd1),
            bit_row(1'b1, 6'd1),
            sym_row(1'b0, NEWLINE_SYMBOL, 1'b0),
            bit_row(1'b1, 6'd31),
            sym_row(1'b1, 8'h00, 1'b0),
            bit_row(1'b0, 6'd1),
            bit_row(1'b0, 6'd1),
            sym_row(1'b0, 8'h80, 1'b0)
        };
        foreach (dir_rows[r])
            repeat (dir_rows[r].reps)
                send_beat(dir_rows[r].bt, dir_rows[r].typed, dir_rows[r].res);

        phase = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            case (phase)
                0:       cnt = CNT_W'(DEPTH);
                1:       cnt = CNT_W'(1);
                2:       cnt = '1;
                3:       cnt = '0;
                default: cnt = ($urandom_range(0, 4) == 0) ? CNT_W'($urandom_range(200, 511))
                                                           : CNT_W'($urandom_range(2, 48));
            endcase
            write_count(cnt);
            span      = (cnt > DEPTH) ? DEPTH : cnt;
            fixed_len = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 5) : 0;
            live_q.delete();
            repeat ($urandom_range(4, 20))
                place_entry(span, fixed_len);

            repeat ($urandom_range(40, 120))
            begin
                if (beats_sent < ITEM_TARGET)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 72 && live_q.size() != 0)
                        feed_code(live_q[$urandom_range(0, live_q.size() - 1)], 1'b0);
                    else if (pick < 84)
                    begin
                        nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 36)
                                                            : $urandom_range(1, 10);
                        repeat (nbits)
                            send_beat(rand_beat(OP_DECODE), 1'b0, '0);
                    end
                    else if (pick < 94 && live_q.size() != 0)
                        feed_code(live_q[$urandom_range(0, live_q.size() - 1)], 1'b1);
                    else
                        place_entry(span, fixed_len);
                end
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (symbol_q.size() != 0)
            @(posedge clk);
        repeat (SEARCH_CYCLES + 16) @(posedge clk);

        $display("sent %0d beats: %0d table loads and %0d coded bits over %0d table sizes",
                 beats_sent, loads_sent, decodes_sent, cfg_writes);
        $display("received %0d symbols and %0d overruns, %0d mismatches",
                 symbols_seen, overflows_seen, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/pcbd_pkg.sv
sv/pcbd_cell.sv
sv/pcbd_chain.sv
sv/prefix_code_bit_decoder.sv
verif/tb_prefix_code_bit_decoder.sv
